// ===== rtl/utf8d_pkg.sv =====
package utf8d_pkg;

  // Result status codes
  localparam logic [2:0] ST_UNIT    = 3'd0;
  localparam logic [2:0] ST_OK      = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_TRUNC   = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  // Lead byte ranges and second-byte limits
  localparam logic [7:0] ASCII_MAX   = 8'h7F;
  localparam logic [7:0] LEAD2_MIN   = 8'hC2;
  localparam logic [7:0] LEAD2_MAX   = 8'hDF;
  localparam logic [7:0] LEAD3_MIN   = 8'hE0;
  localparam logic [7:0] LEAD3_MAX   = 8'hEF;
  localparam logic [7:0] LEAD4_MIN   = 8'hF0;
  localparam logic [7:0] LEAD4_MAX   = 8'hF4;
  localparam logic [7:0] LEAD_E0     = 8'hE0;
  localparam logic [7:0] LEAD_ED     = 8'hED;
  localparam logic [7:0] LEAD_F0     = 8'hF0;
  localparam logic [7:0] LEAD_F4     = 8'hF4;
  localparam logic [7:0] SEC_A0      = 8'hA0;
  localparam logic [7:0] SEC_90      = 8'h90;
  localparam logic [1:0] CONT_TAG    = 2'b10;

  // Surrogate construction
  localparam logic [20:0] BMP_MAX    = 21'h00FFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h010000;
  localparam logic [15:0] HI_SURR    = 16'hD800;
  localparam logic [15:0] LO_SURR    = 16'hDC00;

  localparam logic [15:0] CAP_RESET  = 16'hFFFF;
  localparam int unsigned QUEUE_DEPTH = 4;

  // All results caused by one input byte
  typedef struct packed {
    logic [1:0]  n_units;     // 0, 1 or 2 code units
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic        has_status;  // a status result follows the units
    logic [2:0]  status;
    logic [15:0] count;
  } rec_t;

endpackage

// ===== rtl/utf8d_front.sv =====
module utf8d_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [15:0]           cfg_wr_data,
  input  logic                  acc,          // byte taken this cycle
  input  logic [7:0]            data_byte,
  input  logic                  final_byte,
  output logic                  rec_valid,    // byte yields at least one result
  output utf8d_pkg::rec_t       rec
);
  import utf8d_pkg::*;

  logic [15:0] cap_r;
  logic [20:0] pp_r, pp_nxt;
  logic [7:0]  lead_r, lead_nxt;
  logic [1:0]  due_r, due_nxt;
  logic [1:0]  ci_r, ci_nxt;
  logic [15:0] uw_r, uw_nxt;
  logic        drop_r, drop_nxt;

  logic        err;
  logic [2:0]  err_st;
  logic        done;
  logic [20:0] cp;
  logic [20:0] pp_sh;
  logic [1:0]  due_dec;
  logic [19:0] supp;
  logic        range_bad;

  // Classify the byte and work out the new message state
  always_comb begin
    pp_nxt    = pp_r;
    lead_nxt  = lead_r;
    due_nxt   = due_r;
    ci_nxt    = ci_r;
    uw_nxt    = uw_r;
    drop_nxt  = drop_r;
    err       = 1'b0;
    err_st    = ST_INVALID;
    done      = 1'b0;
    cp        = {13'd0, data_byte};
    pp_sh     = {pp_r[14:0], data_byte[5:0]};
    due_dec   = due_r - 2'd1;
    supp      = '0;
    rec       = '0;
    range_bad = (lead_r == LEAD_E0 && data_byte <  SEC_A0) ||
                (lead_r == LEAD_ED && data_byte >= SEC_A0) ||
                (lead_r == LEAD_F0 && data_byte <  SEC_90) ||
                (lead_r == LEAD_F4 && data_byte >= SEC_90);

    if (drop_r) begin
      if (final_byte) drop_nxt = 1'b0;
    end else if (due_r == 2'd0) begin
      if (data_byte <= ASCII_MAX) begin
        done = 1'b1;
      end else begin
        if (data_byte >= LEAD2_MIN && data_byte <= LEAD2_MAX) begin
          pp_nxt  = {16'd0, data_byte[4:0]};
          due_nxt = 2'd1;
        end else if (data_byte >= LEAD3_MIN && data_byte <= LEAD3_MAX) begin
          pp_nxt  = {17'd0, data_byte[3:0]};
          due_nxt = 2'd2;
        end else if (data_byte >= LEAD4_MIN && data_byte <= LEAD4_MAX) begin
          pp_nxt  = {18'd0, data_byte[2:0]};
          due_nxt = 2'd3;
        end else begin
          err = 1'b1;
        end
        lead_nxt = data_byte;
        ci_nxt   = 2'd0;
        if (!err && final_byte) begin
          err    = 1'b1;
          err_st = ST_TRUNC;
        end
      end
    end else begin
      if (data_byte[7:6] != CONT_TAG) begin
        err = 1'b1;
      end else if (ci_r == 2'd0 && range_bad) begin
        err = 1'b1;
      end else begin
        pp_nxt  = pp_sh;
        ci_nxt  = ci_r + 2'd1;
        due_nxt = due_dec;
        if (due_dec != 2'd0) begin
          if (final_byte) begin
            err    = 1'b1;
            err_st = ST_TRUNC;
          end
        end else begin
          done     = 1'b1;
          cp       = pp_sh;
          pp_nxt   = '0;
          lead_nxt = '0;
          ci_nxt   = 2'd0;
        end
      end
    end

    // Emit the completed point, or flag overflow
    supp = 20'(cp - SUPP_BASE);
    if (done) begin
      if (cp <= BMP_MAX) begin
        if (uw_r >= cap_r) begin
          err    = 1'b1;
          err_st = ST_FULL;
        end else begin
          rec.n_units = 2'd1;
          rec.unit0   = cp[15:0];
          uw_nxt      = uw_r + 16'd1;
        end
      end else begin
        if (({1'b0, uw_r} + 17'd2) > {1'b0, cap_r}) begin
          err    = 1'b1;
          err_st = ST_FULL;
        end else begin
          rec.n_units = 2'd2;
          rec.unit0   = HI_SURR + {6'd0, supp[19:10]};
          rec.unit1   = LO_SURR + {6'd0, supp[9:0]};
          uw_nxt      = uw_r + 16'd2;
        end
      end
      if (!err && final_byte) begin
        rec.has_status = 1'b1;
        rec.status     = ST_OK;
        rec.count      = uw_nxt;
        pp_nxt   = '0;
        lead_nxt = '0;
        due_nxt  = 2'd0;
        ci_nxt   = 2'd0;
        uw_nxt   = '0;
      end
    end

    // First error ends the message
    if (err) begin
      rec            = '0;
      rec.has_status = 1'b1;
      rec.status     = err_st;
      pp_nxt   = '0;
      lead_nxt = '0;
      due_nxt  = 2'd0;
      ci_nxt   = 2'd0;
      uw_nxt   = '0;
      drop_nxt = !final_byte;
    end
  end

  assign rec_valid = (rec.n_units != 2'd0) || rec.has_status;

  // Hold message state; advance on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RESET;
      pp_r   <= '0;
      lead_r <= '0;
      due_r  <= 2'd0;
      ci_r   <= 2'd0;
      uw_r   <= '0;
      drop_r <= 1'b0;
    end else begin
      if (cfg_wr_en) cap_r <= cfg_wr_data;
      if (acc) begin
        pp_r   <= pp_nxt;
        lead_r <= lead_nxt;
        due_r  <= due_nxt;
        ci_r   <= ci_nxt;
        uw_r   <= uw_nxt;
        drop_r <= drop_nxt;
      end
    end
  end

endmodule

// ===== rtl/utf8d_queue.sv =====
module utf8d_queue #(
  parameter int unsigned DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  utf8d_pkg::rec_t push_rec,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output utf8d_pkg::rec_t head_rec
);
  import utf8d_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULLC = CW'(DEPTH);

  rec_t          slot_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full       = (cnt_r == FULLC);
  assign head_valid = (cnt_r != '0);
  assign head_rec   = slot_r[rp_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Store pushed records
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wp_r] <= push_rec;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == LAST) ? '0 : wp_r + PW'(1);
      if (do_pop)  rp_r <= (rp_r == LAST) ? '0 : rp_r + PW'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

// ===== rtl/utf8d_back.sv =====
module utf8d_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  utf8d_pkg::rec_t head_rec,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [31:0]     out_tdata,
  output logic [2:0]      out_tuser,
  output logic            out_tlast
);
  import utf8d_pkg::*;

  logic [1:0]  idx_r, idx_nxt;
  logic        vld_r, vld_nxt;
  logic [15:0] unit_r, unit_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [2:0]  st_r, st_nxt;
  logic        last_r, last_nxt;
  logic [1:0]  n_res;
  logic        load;
  logic        is_last;

  assign n_res   = head_rec.n_units + {1'b0, head_rec.has_status};
  assign load    = head_valid && (!vld_r || out_tready);
  assign is_last = (idx_r == n_res - 2'd1);
  assign pop     = load && is_last;

  // Pick the next result of the head record
  always_comb begin
    idx_nxt  = idx_r;
    vld_nxt  = vld_r;
    unit_nxt = unit_r;
    cnt_nxt  = cnt_r;
    st_nxt   = st_r;
    last_nxt = last_r;
    if (load) begin
      vld_nxt  = 1'b1;
      last_nxt = is_last;
      idx_nxt  = is_last ? 2'd0 : idx_r + 2'd1;
      if (idx_r < head_rec.n_units) begin
        unit_nxt = (idx_r == 2'd0) ? head_rec.unit0 : head_rec.unit1;
        st_nxt   = ST_UNIT;
        cnt_nxt  = '0;
      end else begin
        unit_nxt = '0;
        st_nxt   = head_rec.status;
        cnt_nxt  = head_rec.count;
      end
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  // Hold the output beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unit_r <= unit_nxt;
    cnt_r  <= cnt_nxt;
    st_r   <= st_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {cnt_r, unit_r};
  assign out_tuser  = st_r;
  assign out_tlast  = last_r;

endmodule

// ===== rtl/utf8_to_utf16_validating_decoder.sv =====
// Strict UTF-8 to UTF-16 decoder. One UTF-8 byte per input beat, with in_tlast on the
// last byte of a message; each code point leaves as one UTF-16 unit or a surrogate pair
// (high first), and the message closes with one status beat: accepted with the unit
// count, or the first error (invalid sequence, truncated, output full), after which the
// rest of the message up to its last byte is dropped without results. out_tlast marks
// the last beat caused by one input byte. A byte is accepted every cycle while the
// result queue (QUEUE_DEPTH records) has room; results leave one per cycle from the
// output register while out_tready is high, so a byte yielding two or three beats
// holds the output for all of its beats and sets the sustained rate when such bytes
// are dense. The first result of a byte passes the queue, then the output register.
// Write cfg_wr_data (output capacity, reset 65535) only while the block is idle.
module utf8_to_utf16_validating_decoder #(
  parameter int unsigned QUEUE_DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,   // output_capacity
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] data_byte
  input  logic        in_tlast,      // final_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // [15:0] code_unit, [31:16] unit_count
  output logic [2:0]  out_tuser,     // [2:0] status
  output logic        out_tlast      // run_last
);
  import utf8d_pkg::*;

  logic acc;
  logic rec_valid;
  rec_t rec;
  logic full;
  logic pop;
  logic head_valid;
  rec_t head_rec;

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  // Decode bytes and track message state
  utf8d_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .acc        (acc),
    .data_byte  (in_tdata),
    .final_byte (in_tlast),
    .rec_valid  (rec_valid),
    .rec        (rec)
  );

  // Buffer per-byte result records
  utf8d_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc && rec_valid),
    .push_rec  (rec),
    .full      (full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_rec  (head_rec)
  );

  // Serialize records into output beats
  utf8d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_rec  (head_rec),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule
